FILE: rtl/wdt_pkg.sv
`default_nettype none
package wdt_pkg;

  // function codes of one request
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // register map
  localparam logic [1:0] ADDR_MODE   = 2'd0;
  localparam logic [1:0] ADDR_RELOAD = 2'd1;
  localparam logic [1:0] ADDR_FEED   = 2'd2;
  localparam logic [1:0] ADDR_COUNT  = 2'd3;

  // mode register bit positions
  localparam int MODE_EN  = 0;
  localparam int MODE_RST = 1;
  localparam int MODE_TOF = 2;
  localparam int MODE_INT = 3;

  localparam logic [7:0] FEED_FIRST  = 8'hAA;
  localparam logic [7:0] FEED_SECOND = 8'h55;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              reset_pulse;
    logic              irq_level;
    logic              feed_error;
  } wdt_result_t;

endpackage
`default_nettype wire

FILE: rtl/wdt_if.sv
`default_nettype none
interface wdt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [1:0]                  reg_addr;
  logic [wdt_pkg::DATA_W-1:0]  wdata;

  modport source (output valid, output func, output reg_addr, output wdata, input ready);
  modport sink   (input valid, input func, input reg_addr, input wdata, output ready);
endinterface

interface wdt_out_if;
  logic                        valid;
  logic                        ready;
  logic [wdt_pkg::DATA_W-1:0]  rdata;
  logic                        reset_pulse;
  logic                        irq_level;
  logic                        feed_error;

  modport source (output valid, output rdata, output reset_pulse, output irq_level,
                  output feed_error, input ready);
  modport sink   (input valid, input rdata, input reset_pulse, input irq_level,
                  input feed_error, output ready);
endinterface
`default_nettype wire

FILE: rtl/watchdog_timer_feed_sequence.sv
// channel  | dir | handshake   | payload
// in_chan  | in  | valid/ready | func[1:0], reg_addr[1:0], wdata[31:0]
// out_chan | out | valid/ready | rdata[31:0], reset_pulse, irq_level, feed_error
//
// one request per cycle sustained while out_chan is not stalled; the result is registered after the
// request is accepted (input register, then the watchdog state update into the result register).
// state updates when a request moves from the input register into the result register.
// rst_n is synchronous: clears both stages, mode to 0, timeout constant and count to 255.
// a stalled result holds; the input register still takes one request behind it.
`default_nettype none
module watchdog_timer_feed_sequence #(
  parameter int COUNT_WIDTH  = 32,
  parameter int PRESCALE_DIV = 4,
  parameter int MIN_RELOAD   = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  wdt_in_if.sink          in_chan,
  wdt_out_if.source       out_chan
);

  logic                        in_valid_r;
  logic [1:0]                  func_r;
  logic [1:0]                  addr_r;
  logic [wdt_pkg::DATA_W-1:0]  wdata_r;
  logic                        out_valid_r;
  wdt_pkg::wdt_result_t        out_res_r;
  wdt_pkg::wdt_result_t        res;
  logic                        advance;

  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      func_r  <= in_chan.func;
      addr_r  <= in_chan.reg_addr;
      wdata_r <= in_chan.wdata;
    end
  end

  wdt_core #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .PRESCALE_DIV (PRESCALE_DIV),
    .MIN_RELOAD   (MIN_RELOAD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (advance),
    .func     (func_r),
    .reg_addr (addr_r),
    .wdata    (wdata_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.rdata       = out_res_r.rdata;
  assign out_chan.reset_pulse = out_res_r.reset_pulse;
  assign out_chan.irq_level   = out_res_r.irq_level;
  assign out_chan.feed_error  = out_res_r.feed_error;

endmodule
`default_nettype wire

FILE: rtl/wdt_core.sv
`default_nettype none
module wdt_core #(
  parameter int COUNT_WIDTH  = 32,
  parameter int PRESCALE_DIV = 4,
  parameter int MIN_RELOAD   = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [1:0]                  func,
  input  wire logic [1:0]                  reg_addr,
  input  wire logic [wdt_pkg::DATA_W-1:0]  wdata,
  output wdt_pkg::wdt_result_t             res
);

  localparam int PS_W = (PRESCALE_DIV > 1) ? $clog2(PRESCALE_DIV) : 1;
  localparam logic [PS_W-1:0]        PS_LAST   = PS_W'(PRESCALE_DIV - 1);
  localparam logic [COUNT_WIDTH-1:0] RELOAD_MIN = COUNT_WIDTH'(MIN_RELOAD);
  localparam logic [COUNT_WIDTH-1:0] RESET_VAL  = COUNT_WIDTH'(255);

  logic [3:0]             mode_r,   mode_nxt;
  logic [COUNT_WIDTH-1:0] reload_r, reload_nxt;
  logic [COUNT_WIDTH-1:0] count_r,  count_nxt;
  logic [PS_W-1:0]        ps_r,     ps_nxt;
  logic                   armed_r,  armed_nxt;
  logic                   run_r,    run_nxt;

  always_comb begin
    logic [COUNT_WIDTH-1:0] v;
    v          = wdata[COUNT_WIDTH-1:0];
    mode_nxt   = mode_r;
    reload_nxt = reload_r;
    count_nxt  = count_r;
    ps_nxt     = ps_r;
    armed_nxt  = armed_r;
    run_nxt    = run_r;
    res        = '0;
    if (go) begin
      case (func)
        wdt_pkg::FUNC_TICK: begin
          if (run_r && mode_r[wdt_pkg::MODE_EN]) begin
            if (ps_r == PS_LAST) begin
              ps_nxt = '0;
              if (count_r > COUNT_WIDTH'(1)) begin
                count_nxt = count_r - COUNT_WIDTH'(1);
              end else begin
                count_nxt = reload_r;
                if (mode_r[wdt_pkg::MODE_RST]) begin
                  res.reset_pulse = 1'b1;
                  mode_nxt = '0;
                  mode_nxt[wdt_pkg::MODE_TOF] = 1'b1;
                  run_nxt   = 1'b0;
                  armed_nxt = 1'b0;
                end else begin
                  mode_nxt[wdt_pkg::MODE_TOF] = 1'b1;
                  mode_nxt[wdt_pkg::MODE_INT] = 1'b1;
                end
              end
            end else begin
              ps_nxt = ps_r + PS_W'(1);
            end
          end
        end
        wdt_pkg::FUNC_WRITE: begin
          case (reg_addr)
            wdt_pkg::ADDR_MODE: begin
              // enable and reset-enable are set-only, timeout flag clears on 0
              mode_nxt[wdt_pkg::MODE_EN]  = mode_r[wdt_pkg::MODE_EN]  | wdata[wdt_pkg::MODE_EN];
              mode_nxt[wdt_pkg::MODE_RST] = mode_r[wdt_pkg::MODE_RST] | wdata[wdt_pkg::MODE_RST];
              if (!wdata[wdt_pkg::MODE_TOF]) mode_nxt[wdt_pkg::MODE_TOF] = 1'b0;
            end
            wdt_pkg::ADDR_RELOAD: begin
              reload_nxt = (v < RELOAD_MIN) ? RELOAD_MIN : v;
            end
            wdt_pkg::ADDR_FEED: begin
              if (armed_r) begin
                armed_nxt = 1'b0;
                if (wdata[7:0] == wdt_pkg::FEED_SECOND) begin
                  if (mode_r[wdt_pkg::MODE_EN]) begin
                    count_nxt = reload_r;
                    ps_nxt    = '0;
                    run_nxt   = 1'b1;
                  end
                end else begin
                  res.feed_error = 1'b1;
                end
              end else if (wdata[7:0] == wdt_pkg::FEED_FIRST) begin
                armed_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
        wdt_pkg::FUNC_READ: begin
          case (reg_addr)
            wdt_pkg::ADDR_MODE:   res.rdata = wdt_pkg::DATA_W'(mode_r);
            wdt_pkg::ADDR_RELOAD: res.rdata = wdt_pkg::DATA_W'(reload_r);
            wdt_pkg::ADDR_COUNT:  res.rdata = wdt_pkg::DATA_W'(count_r);
            default:              res.rdata = '0;
          endcase
        end
        default: ;
      endcase
    end
    res.irq_level = mode_nxt[wdt_pkg::MODE_INT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      reload_r <= RESET_VAL;
      count_r  <= RESET_VAL;
      ps_r     <= '0;
      armed_r  <= 1'b0;
      run_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      reload_r <= reload_nxt;
      count_r  <= count_nxt;
      ps_r     <= ps_nxt;
      armed_r  <= armed_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wdt_checker.sv
`default_nettype none
module wdt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_rdata,
  input wire logic        out_reset_pulse,
  input wire logic        out_irq_level,
  input wire logic        out_feed_error
);

  // no result shows in the cycle after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a watchdog reset clears the interrupt flag
  a_reset_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reset_pulse) |-> !out_irq_level)
    else $error("interrupt flag set with reset pulse");

  // reset pulse comes from ticks, feed error from writes
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_reset_pulse && out_feed_error))
    else $error("reset pulse and feed error together");

  // only reads return data
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_reset_pulse || out_feed_error)) |-> (out_rdata == 32'd0))
    else $error("read data on a tick or write");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rdata)
      && $stable(out_reset_pulse) && $stable(out_irq_level) && $stable(out_feed_error)))
    else $error("stalled result changed");

endmodule

bind watchdog_timer_feed_sequence wdt_checker u_wdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_rdata       (out_chan.rdata),
  .out_reset_pulse (out_chan.reset_pulse),
  .out_irq_level   (out_chan.irq_level),
  .out_feed_error  (out_chan.feed_error)
);
`default_nettype wire
